FILE: sv/assert_macros.svh
// ------------------------------------------------------------------------
// assertion macros
// shared wrappers for concurrent assertions with and without reset gating
// ------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked only while out of reset
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked at every edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/biu_pkg.sv
// ------------------------------------------------------------------------
// biu_pkg
// shared constants and types of the bilinear upscaler
// ------------------------------------------------------------------------
package biu_pkg;

    localparam int SRC_WIDTH  = 384;
    localparam int SRC_HEIGHT = 288;

    localparam int CFG_W   = 13;
    localparam int COORD_W = 12;
    localparam int SRCC_W  = 9;
    localparam int CH_W    = 8;
    localparam int PIX_W   = 3 * CH_W;
    localparam int FRAC_W  = 9;

    localparam int XI_W = $clog2(SRC_WIDTH);
    localparam int YI_W = $clog2(SRC_HEIGHT);

    // scale numerators (source size minus one, in 1/256 pixel)
    localparam int KX = (SRC_WIDTH - 1) * 256;
    localparam int KY = (SRC_HEIGHT - 1) * 256;
    localparam int KW = $clog2(((KX > KY) ? KX : KY) + 1);
    localparam int PW = COORD_W + KW;

    localparam int BANK_D = ((SRC_HEIGHT + 1) / 2) * SRC_WIDTH;
    localparam int AW     = $clog2(BANK_D);

    localparam int FIFO_D  = 4;
    localparam int FIFO_AW = $clog2(FIFO_D);

    localparam int IN_RAW_W    = 2 * SRCC_W + 3 * CH_W + 2 * COORD_W;
    localparam int IN_TDATA_W  = ((IN_RAW_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = PIX_W;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_HEIGHT = 1'b1;

    localparam int OUT_WIDTH_RST  = 1024;
    localparam int OUT_HEIGHT_RST = 768;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    typedef struct packed {
        logic                is_read;
        logic [SRCC_W-1:0]   src_x;
        logic [SRCC_W-1:0]   src_y;
        logic [PIX_W-1:0]    pix;
        logic [COORD_W-1:0]  out_x;
        logic [COORD_W-1:0]  out_y;
    } t_req;

    typedef struct packed {
        logic                is_read;
        logic                wr_ok;
        logic [XI_W-1:0]     wr_x;
        logic [YI_W-1:0]     wr_y;
        logic [PIX_W-1:0]    wr_pix;
        logic [XI_W-1:0]     xi;
        logic [FRAC_W-1:0]   fx;
        logic [YI_W-1:0]     yi;
        logic [FRAC_W-1:0]   fy;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic full;
    } t_fifo_st;

endpackage

FILE: sv/bilinear_image_upscaler_unit.sv
// path: an input beat passes the front divider stages, the queue and the back stages to the result beat
// KW (17 here) is the depth of the pipelined coordinate divider in the front
// throughput: one beat per cycle, reads and writes alike, unless the queue fills under a result stall
// reset: synchronous active low, clears pipeline valids, queue and sizes
// (1024x768); pixel store content is undefined until written
// ------------------------------------------------------------------------
// bilinear_image_upscaler_unit
// source image store with bilinear readout at a programmable output size
// ------------------------------------------------------------------------
module bilinear_image_upscaler_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input beat
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // src_x[8:0] src_y[17:9] red_in[25:18] green_in[33:26] blue_in[41:34]
    // out_x[53:42] out_y[65:54], zero above
    input  logic [biu_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // operation
    input  logic                                s_axis_tuser,
    // result beat
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // red_out[7:0] green_out[15:8] blue_out[23:16]
    output logic [biu_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    // register writes
    input  logic                                i_cfg_we,
    input  logic [biu_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [biu_pkg::CFG_W-1:0]           i_cfg_data
);
    import biu_pkg::*;

    localparam int XO = 0;
    localparam int YO = XO + SRCC_W;
    localparam int RO = YO + SRCC_W;
    localparam int GO = RO + CH_W;
    localparam int BO = GO + CH_W;
    localparam int OXO = BO + CH_W;
    localparam int OYO = OXO + COORD_W;

    // divisors (size - 1, at least 1) kept instead of the sizes themselves
    logic [CFG_W-1:0] r_dx;
    logic [CFG_W-1:0] r_dy;
    logic [CFG_W-1:0] n_d;

    t_req       req;
    t_cmd       push_cmd;
    t_cmd       pop_cmd;
    t_fifo_st   fst;
    logic       push;
    logic       pop;
    logic [PIX_W-1:0] pix;

    assign n_d = (i_cfg_data > CFG_W'(1)) ? (i_cfg_data - 1'b1) : CFG_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dx <= CFG_W'(OUT_WIDTH_RST - 1);
            r_dy <= CFG_W'(OUT_HEIGHT_RST - 1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_OUT_WIDTH:  r_dx <= n_d;
                CFG_OUT_HEIGHT: r_dy <= n_d;
                default:        r_dx <= r_dx;
            endcase
        end
    end

    // unpack the beat; pixel kept as r,g,b from the top down
    always_comb begin
        req.is_read = s_axis_tuser;
        req.src_x   = s_axis_tdata[XO +: SRCC_W];
        req.src_y   = s_axis_tdata[YO +: SRCC_W];
        req.pix     = {s_axis_tdata[RO +: CH_W], s_axis_tdata[GO +: CH_W],
                       s_axis_tdata[BO +: CH_W]};
        req.out_x   = s_axis_tdata[OXO +: COORD_W];
        req.out_y   = s_axis_tdata[OYO +: COORD_W];
    end

    // front: classify and map coordinates
    biu_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_req   (req),
        .i_dx    (r_dx),
        .i_dy    (r_dy),
        .i_fst   (fst),
        .o_push  (push),
        .o_cmd   (push_cmd)
    );

    // queue decouples the divider pipe from store and output stalls
    biu_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_cmd),
        .i_pop   (pop),
        .o_data  (pop_cmd),
        .o_st    (fst)
    );

    // back: store access and interpolation
    biu_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (!fst.empty),
        .o_pop   (pop),
        .i_cmd   (pop_cmd),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_pix   (pix)
    );

    // red lowest on the bus
    assign m_axis_tdata = {pix[0 +: CH_W], pix[CH_W +: CH_W], pix[2*CH_W +: CH_W]};

endmodule

FILE: sv/biu_front.sv
// ------------------------------------------------------------------------
// biu_front
// accepts beats, sorts writes from reads, maps output coords to source
// ------------------------------------------------------------------------
module biu_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  biu_pkg::t_req                i_req,
    input  logic [biu_pkg::CFG_W-1:0]    i_dx,
    input  logic [biu_pkg::CFG_W-1:0]    i_dy,
    input  biu_pkg::t_fifo_st            i_fst,
    output logic                         o_push,
    output biu_pkg::t_cmd                o_cmd
);
    import biu_pkg::*;

    typedef struct packed {
        logic              is_read;
        logic              wr_ok;
        logic [XI_W-1:0]   wr_x;
        logic [YI_W-1:0]   wr_y;
        logic [PIX_W-1:0]  wr_pix;
        logic              sat_x;
        logic              sat_y;
        logic [CFG_W-1:0]  rem_x;
        logic [CFG_W-1:0]  rem_y;
        logic [KW-1:0]     num_x;
        logic [KW-1:0]     num_y;
    } t_fstage;

    // one restoring step per axis, quotient bits shift in at the bottom
    function automatic t_fstage div_step(t_fstage s, logic [CFG_W-1:0] dx,
                                         logic [CFG_W-1:0] dy);
        t_fstage      o;
        logic [CFG_W:0] tx;
        logic [CFG_W:0] ty;
        o  = s;
        tx = {s.rem_x, s.num_x[KW-1]};
        ty = {s.rem_y, s.num_y[KW-1]};
        if (tx >= {1'b0, dx}) begin
            o.rem_x = CFG_W'(tx - {1'b0, dx});
            o.num_x = {s.num_x[KW-2:0], 1'b1};
        end else begin
            o.rem_x = tx[CFG_W-1:0];
            o.num_x = {s.num_x[KW-2:0], 1'b0};
        end
        if (ty >= {1'b0, dy}) begin
            o.rem_y = CFG_W'(ty - {1'b0, dy});
            o.num_y = {s.num_y[KW-2:0], 1'b1};
        end else begin
            o.rem_y = ty[CFG_W-1:0];
            o.num_y = {s.num_y[KW-2:0], 1'b0};
        end
        return o;
    endfunction

    logic            en;
    logic [KW:0]     r_vld;
    t_fstage         r_st [KW+1];
    t_fstage         n_st0;
    logic [PW-1:0]   prod_x;
    logic [PW-1:0]   prod_y;
    t_fstage         last;

    assign en      = !(r_vld[KW] && i_fst.full);
    assign o_ready = en;
    assign o_push  = r_vld[KW] && en;

    assign prod_x = PW'(i_req.out_x) * PW'(KX);
    assign prod_y = PW'(i_req.out_y) * PW'(KY);

    always_comb begin
        n_st0.is_read = i_req.is_read;
        n_st0.wr_ok   = (i_req.src_x < SRC_WIDTH) && (i_req.src_y < SRC_HEIGHT);
        n_st0.wr_x    = XI_W'(i_req.src_x);
        n_st0.wr_y    = YI_W'(i_req.src_y);
        n_st0.wr_pix  = i_req.pix;
        // past the last pair whenever coord >= divisor
        n_st0.sat_x   = CFG_W'(i_req.out_x) >= i_dx;
        n_st0.sat_y   = CFG_W'(i_req.out_y) >= i_dy;
        n_st0.rem_x   = CFG_W'(prod_x[PW-1:KW]);
        n_st0.rem_y   = CFG_W'(prod_y[PW-1:KW]);
        n_st0.num_x   = prod_x[KW-1:0];
        n_st0.num_y   = prod_y[KW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[KW-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_st[0] <= n_st0;
            for (int k = 1; k <= KW; k++) begin
                r_st[k] <= div_step(r_st[k-1], i_dx, i_dy);
            end
        end
    end

    assign last = r_st[KW];

    always_comb begin
        o_cmd.is_read = last.is_read;
        o_cmd.wr_ok   = last.wr_ok;
        o_cmd.wr_x    = last.wr_x;
        o_cmd.wr_y    = last.wr_y;
        o_cmd.wr_pix  = last.wr_pix;
        o_cmd.xi = last.sat_x ? XI_W'(SRC_WIDTH - 2) : last.num_x[8 +: XI_W];
        o_cmd.fx = last.sat_x ? FRAC_W'(256) : {1'b0, last.num_x[7:0]};
        o_cmd.yi = last.sat_y ? YI_W'(SRC_HEIGHT - 2) : last.num_y[8 +: YI_W];
        o_cmd.fy = last.sat_y ? FRAC_W'(256) : {1'b0, last.num_y[7:0]};
    end

endmodule

FILE: sv/biu_fifo.sv
// ------------------------------------------------------------------------
// biu_fifo
// short command queue between front and back
// ------------------------------------------------------------------------
module biu_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  biu_pkg::t_cmd      i_data,
    input  logic               i_pop,
    output biu_pkg::t_cmd      o_data,
    output biu_pkg::t_fifo_st  o_st
);
    import biu_pkg::*;

    t_cmd               r_mem [FIFO_D];
    logic [FIFO_AW-1:0] r_wp;
    logic [FIFO_AW-1:0] r_rp;
    logic [FIFO_AW:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (FIFO_AW+1)'(i_push) - (FIFO_AW+1)'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end

    assign o_data   = r_mem[r_rp];
    assign o_st.empty = (r_cnt == '0);
    assign o_st.full  = (r_cnt == (FIFO_AW+1)'(FIFO_D));

endmodule

FILE: sv/biu_back.sv
// ------------------------------------------------------------------------
// biu_back
// row-banked pixel store, horizontal then vertical lerp, output register
// ------------------------------------------------------------------------
module biu_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_pop,
    input  biu_pkg::t_cmd                i_cmd,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [biu_pkg::PIX_W-1:0]    o_pix
);
    import biu_pkg::*;

    localparam int PROD_W = CH_W + FRAC_W + 2;

    // a + floor((b - a) * f / 256)
    function automatic logic [CH_W-1:0] lerp(logic [CH_W-1:0] a, logic [CH_W-1:0] b,
                                             logic [FRAC_W-1:0] f);
        logic signed [CH_W:0]     diff;
        logic signed [PROD_W-1:0] prod;
        diff = $signed({1'b0, b}) - $signed({1'b0, a});
        prod = diff * $signed({1'b0, f});
        return a + CH_W'(prod >>> 8);
    endfunction

    logic en;

    // stage 0: addresses
    logic              r_v0, r_rd0, r_we0, r_wbank0, r_swap0;
    logic [AW-1:0]     r_wa0, r_ra_e0, r_ra_o0;
    logic [PIX_W-1:0]  r_wd0;
    logic [FRAC_W-1:0] r_fx0, r_fy0;
    // stage 1: store read
    logic              r_v1, r_rd1, r_swap1;
    logic [FRAC_W-1:0] r_fx1, r_fy1;
    logic [PIX_W-1:0]  r_pe0, r_pe1, r_po0, r_po1;
    // stage 2: horizontal lerp
    logic              r_v2, r_rd2;
    logic [FRAC_W-1:0] r_fy2;
    logic [CH_W-1:0]   r_t0 [3];
    logic [CH_W-1:0]   r_t1 [3];
    // output
    logic              r_ovld;
    logic [PIX_W-1:0]  r_opix;

    logic [PIX_W-1:0]  mem_e [BANK_D];
    logic [PIX_W-1:0]  mem_o [BANK_D];

    logic [YI_W-1:0]   row_a, row_b, row_e, row_o;
    logic [AW-1:0]     n_ra_e, n_ra_o, n_wa;
    logic [PIX_W-1:0]  p00, p01, p10, p11;
    logic [CH_W-1:0]   n_v [3];

    assign en    = !r_ovld || i_ready;
    assign o_pop = en && i_valid;

    always_comb begin
        row_a  = i_cmd.yi;
        row_b  = i_cmd.yi + 1'b1;
        // even rows live in one bank, odd rows in the other
        row_e  = i_cmd.yi[0] ? row_b : row_a;
        row_o  = i_cmd.yi[0] ? row_a : row_b;
        n_ra_e = AW'(row_e >> 1) * AW'(SRC_WIDTH) + AW'(i_cmd.xi);
        n_ra_o = AW'(row_o >> 1) * AW'(SRC_WIDTH) + AW'(i_cmd.xi);
        n_wa   = AW'(i_cmd.wr_y >> 1) * AW'(SRC_WIDTH) + AW'(i_cmd.wr_x);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0   <= 1'b0;
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_ovld <= 1'b0;
        end else if (en) begin
            r_v0   <= i_valid;
            r_v1   <= r_v0;
            r_v2   <= r_v1;
            r_ovld <= r_v2 && r_rd2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rd0    <= i_cmd.is_read;
            r_we0    <= (i_cmd.is_read == OP_WRITE) && i_cmd.wr_ok;
            r_wbank0 <= i_cmd.wr_y[0];
            r_wa0    <= n_wa;
            r_wd0    <= i_cmd.wr_pix;
            r_ra_e0  <= n_ra_e;
            r_ra_o0  <= n_ra_o;
            r_swap0  <= i_cmd.yi[0];
            r_fx0    <= i_cmd.fx;
            r_fy0    <= i_cmd.fy;

            r_rd1    <= r_rd0;
            r_swap1  <= r_swap0;
            r_fx1    <= r_fx0;
            r_fy1    <= r_fy0;

            r_rd2    <= r_rd1;
            r_fy2    <= r_fy1;
            for (int k = 0; k < 3; k++) begin
                r_t0[k] <= lerp(p00[k*CH_W +: CH_W], p01[k*CH_W +: CH_W], r_fx1);
                r_t1[k] <= lerp(p10[k*CH_W +: CH_W], p11[k*CH_W +: CH_W], r_fx1);
                r_opix[k*CH_W +: CH_W] <= n_v[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && r_v0 && r_we0 && !r_wbank0) mem_e[r_wa0] <= r_wd0;
        if (en) begin
            r_pe0 <= mem_e[r_ra_e0];
            r_pe1 <= mem_e[r_ra_e0 + 1'b1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && r_v0 && r_we0 && r_wbank0) mem_o[r_wa0] <= r_wd0;
        if (en) begin
            r_po0 <= mem_o[r_ra_o0];
            r_po1 <= mem_o[r_ra_o0 + 1'b1];
        end
    end

    always_comb begin
        p00 = r_swap1 ? r_po0 : r_pe0;
        p01 = r_swap1 ? r_po1 : r_pe1;
        p10 = r_swap1 ? r_pe0 : r_po0;
        p11 = r_swap1 ? r_pe1 : r_po1;
        for (int k = 0; k < 3; k++) begin
            n_v[k] = lerp(r_t0[k], r_t1[k], r_fy2);
        end
    end

    assign o_valid = r_ovld;
    assign o_pix   = r_opix;

endmodule

FILE: sv/biu_checker.sv
// ------------------------------------------------------------------------
// biu_checker
// port-level checks of the upscaler, bound to the top level
// ------------------------------------------------------------------------
`include "assert_macros.svh"

module biu_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tready,
    input  logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    input  logic [biu_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
    // result must hold while stalled
    `ASSERT_RST(a_hold_data, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata), "result changed under stall")

    // input backs up only once the result side has stalled
    `ASSERT_RST(a_ready_cause, i_clk, i_rst_n, !s_axis_tready |-> $past(m_axis_tvalid && !m_axis_tready), "input stalled without output stall")

    // nothing comes out right after reset
    `ASSERT_ALWAYS(a_rst_idle, i_clk, !i_rst_n |=> !m_axis_tvalid, "result valid after reset")

endmodule

bind bilinear_image_upscaler_unit biu_checker u_chk (.*);

FILE: test/bilinear_image_upscaler_unit_tb.sv
// ------------------------------------------------------------------------
// bilinear_image_upscaler_unit_tb
// fills tiles of the source image, then reads output pixels at several output
// sizes and checks each result beat against a bilinear predictor in the bench
// ------------------------------------------------------------------------
module bilinear_image_upscaler_unit_tb;
    import biu_pkg::*;

    localparam int DRAIN_CYCLES = 60;
    localparam int STALL_LIMIT  = 20000;
    localparam int TILE         = 4;
    localparam int RAND_TILES   = 15;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    // src_x, src_y, red_in, green_in, blue_in, out_x, out_y from bit 0 up
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    // operation
    logic                   s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    // red_out, green_out, blue_out from bit 0 up
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   i_cfg_we;
    logic [CFG_IDX_W-1:0]   i_cfg_idx;
    logic [CFG_W-1:0]       i_cfg_data;

    bilinear_image_upscaler_unit u_top (.*);

    // bench copy of the image and the output size
    logic [PIX_W-1:0] image_mem [SRC_WIDTH*SRC_HEIGHT];
    bit               written [SRC_WIDTH*SRC_HEIGHT];
    logic [CFG_W-1:0] width_reg, height_reg;
    logic [PIX_W-1:0] pixel_q [$];
    int               tile_x [$];
    int               tile_y [$];

    int  mismatches;
    bit  noisy_in, noisy_out, hold_off;
    int  idle_cycles;

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    // source position of an output coordinate, last pixel saturated
    function automatic void map_axis(input int c, input int n, input int s,
                                     output int idx, output int frac);
        longint dv, q;
        dv = (n > 1) ? n - 1 : 1;
        q  = (longint'(c) * (s - 1) * 256) / dv;
        if ((q >> 8) > s - 2) begin
            idx = s - 2; frac = 256;
        end else begin
            idx = int'(q >> 8); frac = int'(q & 255);
        end
    endfunction

    function automatic int blend(int a, int b, int f);
        return a + (((b - a) * f) >>> 8);
    endfunction

    function automatic logic [PIX_W-1:0] upscale_pixel(int ox, int oy);
        int xi, fx, yi, fy, t0, t1, sh;
        logic [PIX_W-1:0] p00, p01, p10, p11, res;
        map_axis(ox, width_reg, SRC_WIDTH, xi, fx);
        map_axis(oy, height_reg, SRC_HEIGHT, yi, fy);
        p00 = image_mem[yi*SRC_WIDTH + xi];
        p01 = image_mem[yi*SRC_WIDTH + xi + 1];
        p10 = image_mem[(yi+1)*SRC_WIDTH + xi];
        p11 = image_mem[(yi+1)*SRC_WIDTH + xi + 1];
        // store holds r,g,b high to low; result puts red in the low byte
        for (int k = 0; k < 3; k++) begin
            sh = 16 - 8*k;
            t0 = blend((p00 >> sh) & 255, (p01 >> sh) & 255, fx);
            t1 = blend((p10 >> sh) & 255, (p11 >> sh) & 255, fx);
            res[8*k +: 8] = 8'(blend(t0, t1, fy));
        end
        return res;
    endfunction

    // all four neighbors of the mapped position hold written pixels
    function automatic bit covered(int ox, int oy);
        int xi, fx, yi, fy;
        map_axis(ox, width_reg, SRC_WIDTH, xi, fx);
        map_axis(oy, height_reg, SRC_HEIGHT, yi, fy);
        return written[yi*SRC_WIDTH + xi] && written[yi*SRC_WIDTH + xi + 1] &&
               written[(yi+1)*SRC_WIDTH + xi] && written[(yi+1)*SRC_WIDTH + xi + 1];
    endfunction

    // output coordinate landing on a source position, or a little past it
    function automatic int aim(int pos, int n, int s);
        int dv;
        dv = (n > 1) ? n - 1 : 1;
        return (pos * dv + s - 2) / (s - 1) + $urandom_range(dv / (s - 1));
    endfunction

    // read coordinate on written tiles, falls back to the top left corner
    function automatic void pick_read(output int ox, output int oy);
        int t, cx, cy;
        bit hit;
        ox = 0; oy = 0; hit = 1'b0;
        for (int k = 0; k < 200 && !hit; k++) begin
            if ($urandom_range(9) == 0) begin
                cx = $urandom_range(4095);
                cy = $urandom_range(4095);
            end else begin
                t  = $urandom_range(tile_x.size() - 1);
                cx = aim(tile_x[t] + $urandom_range(TILE - 2), width_reg, SRC_WIDTH);
                cy = aim(tile_y[t] + $urandom_range(TILE - 2), height_reg, SRC_HEIGHT);
            end
            if (cx <= 4095 && cy <= 4095 && covered(cx, cy)) begin
                ox = cx; oy = cy; hit = 1'b1;
            end
        end
    endfunction

    task automatic send_beat(input logic op, input int sx, input int sy,
                             input logic [PIX_W-1:0] rgb, input int ox, input int oy);
        logic [IN_TDATA_W-1:0] d;
        while (noisy_in && $urandom_range(99) < 35) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        d = '0;
        d[8:0] = 9'(sx); d[17:9] = 9'(sy);
        d[25:18] = rgb[23:16]; d[33:26] = rgb[15:8]; d[41:34] = rgb[7:0];
        d[53:42] = 12'(ox); d[65:54] = 12'(oy);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        // predict at acceptance
        if (op == OP_WRITE) begin
            if (sx < SRC_WIDTH && sy < SRC_HEIGHT) begin
                image_mem[sy*SRC_WIDTH + sx] = rgb;
                written[sy*SRC_WIDTH + sx]   = 1'b1;
            end
        end else begin
            pixel_q.push_back(upscale_pixel(ox, oy));
        end
    endtask

    task automatic write_pixel(int sx, int sy, logic [PIX_W-1:0] rgb);
        send_beat(OP_WRITE, sx, sy, rgb, $urandom_range(4095), $urandom_range(4095));
    endtask

    task automatic read_pixel(int ox, int oy);
        send_beat(OP_READ, $urandom_range(511), $urandom_range(511), PIX_W'($urandom),
                  ox, oy);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pixel_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_size(int w, int h);
        @(posedge i_clk);
        i_cfg_we <= 1'b1; i_cfg_idx <= CFG_OUT_WIDTH; i_cfg_data <= CFG_W'(w);
        @(posedge i_clk);
        i_cfg_idx <= CFG_OUT_HEIGHT; i_cfg_data <= CFG_W'(h);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        width_reg = CFG_W'(w); height_reg = CFG_W'(h);
    endtask

    // corner tiles, one mid-row tile and random tiles, so reads hit written pixels
    task automatic test_fill_image();
        tile_x = '{0, SRC_WIDTH-TILE, 0, SRC_WIDTH-TILE, 190};
        tile_y = '{0, 0, SRC_HEIGHT-TILE, SRC_HEIGHT-TILE, 0};
        for (int t = 0; t < RAND_TILES; t++) begin
            tile_x.push_back($urandom_range(SRC_WIDTH-TILE));
            tile_y.push_back($urandom_range(SRC_HEIGHT-TILE));
        end
        for (int t = 0; t < tile_x.size(); t++)
            for (int y = 0; y < TILE; y++)
                for (int x = 0; x < TILE; x++)
                    write_pixel(tile_x[t] + x, tile_y[t] + y, PIX_W'($urandom));
    endtask

    task automatic test_directed();
        // writes outside the image are dropped, then pixels at two corners are written
        write_pixel(SRC_WIDTH, 0, 24'hFFFFFF);
        write_pixel(0, SRC_HEIGHT, 24'hFFFFFF);
        write_pixel(511, 511, 24'h000000);
        write_pixel(0, 0, 24'h000000);
        write_pixel(1, 0, 24'hFFFFFF);
        write_pixel(SRC_WIDTH-1, SRC_HEIGHT-1, 24'hFFFFFF);
        // reset size 1024x768, then corners and past-the-end coordinates
        read_pixel(0, 0);
        read_pixel(1, 1);
        read_pixel(1023, 767);
        read_pixel(4095, 4095);
        read_pixel(4095, 0);
        read_pixel(2730, 1365);
        wait_idle();
        set_size(1, 1);            // divisor of one
        read_pixel(0, 0);
        read_pixel(1, 1);
        wait_idle();
        set_size(0, 0);
        read_pixel(0, 0);
        read_pixel(3, 2);
        wait_idle();
        set_size(4096, 4096);
        read_pixel(4095, 4095);
        read_pixel(2048, 1);
        read_pixel(0, 4094);
        wait_idle();
    endtask

    task automatic test_random(int n, int w, int h);
        int ox, oy;
        set_size(w, h);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(9) < 2) begin
                write_pixel($urandom_range(SRC_WIDTH+20), $urandom_range(SRC_HEIGHT+20),
                            PIX_W'($urandom));
            end else begin
                pick_read(ox, oy);
                read_pixel(ox, oy);
            end
        end
        wait_idle();
    endtask

    // receiver holds off while the sender keeps offering reads
    task automatic test_back_pressure();
        int ox, oy;
        hold_off = 1'b1;
        fork
            begin
                repeat (300) @(posedge i_clk);
                hold_off = 1'b0;
            end
            for (int i = 0; i < 60; i++) begin
                pick_read(ox, oy);
                read_pixel(ox, oy);
            end
        join
        wait_idle();
    endtask

    // result side: random ready, compare with oldest prediction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (pixel_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result beat %h", m_axis_tdata);
                end else if (pixel_q[0] !== m_axis_tdata) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("pixel mismatch: expected %h actual %h",
                                 pixel_q[0], m_axis_tdata);
                    void'(pixel_q.pop_front());
                end else begin
                    void'(pixel_q.pop_front());
                end
            end
            m_axis_tready <= !hold_off && !(noisy_out && $urandom_range(99) < 35);
        end
    end

    // watchdog on cycles without any accepted beat or register write
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || i_cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("bilinear_image_upscaler_unit_tb: errors");
            $finish;
        end
    end

    initial begin
        mismatches = 0; idle_cycles = 0; hold_off = 1'b0;
        noisy_in = 1'b0; noisy_out = 1'b0;
        i_rst_n = 1'b0; s_axis_tvalid = 1'b0; s_axis_tdata = '0; s_axis_tuser = 1'b0;
        i_cfg_we = 1'b0; i_cfg_idx = '0; i_cfg_data = '0;
        width_reg = CFG_W'(OUT_WIDTH_RST); height_reg = CFG_W'(OUT_HEIGHT_RST);
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_fill_image();         // long run with no idling
        noisy_in = 1'b1; noisy_out = 1'b1;
        test_directed();
        test_random(200, 1024, 768);
        test_random(150, 640, 480);
        test_random(120, 4096, 4096);
        test_random(80, 2, 3);
        test_random(60, 384, 288);
        test_back_pressure();
        noisy_in = 1'b0; noisy_out = 1'b0;
        test_random(80, 1, 4096);
        if (mismatches == 0 && pixel_q.size() == 0)
            $display("bilinear_image_upscaler_unit_tb: clean");
        else
            $display("bilinear_image_upscaler_unit_tb: errors");
        $finish;
    end
endmodule

FILE: filelist.f
+incdir+sv
sv/biu_pkg.sv
sv/biu_front.sv
sv/biu_fifo.sv
sv/biu_back.sv
sv/bilinear_image_upscaler_unit.sv
sv/biu_checker.sv
test/bilinear_image_upscaler_unit_tb.sv
